FILE: sv/uerm_pkg.sv
package uerm_pkg;

   // Item kind carried on the request side
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_START = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_MEDIAN_MODE   = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_COUNT  = 3'd1;
   localparam logic [2:0] CSR_MAX_ECHO      = 3'd2;
   localparam logic [2:0] CSR_START_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_PING_GAP      = 3'd4;

   // Configuration reset values
   localparam logic        RST_MEDIAN_MODE   = 1'b0;
   localparam logic [4:0]  RST_SAMPLE_COUNT  = 5'd5;
   localparam logic [15:0] RST_MAX_ECHO      = 16'd4018;
   localparam logic [15:0] RST_START_TIMEOUT = 16'd18000;
   localparam logic [7:0]  RST_PING_GAP      = 8'd29;

   // Ping timing
   localparam int TRIG_LOW_TICKS  = 4;
   localparam int TRIG_HIGH_TICKS = 10;
   localparam int ECHO_OVERHEAD   = 5;
   localparam int GAP_W           = 18;
   localparam int GAP_US_PER_MS   = 1000;

   // Time to centimeters: (t + 28) / 57 through a reciprocal and one correction
   localparam int CM_ROUND = 28;
   localparam int CM_DIV   = 57;
   localparam int CM_RECIP = 1149;

   // Ping phase
   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_TRIG_LOW   = 7'b0000010,
      PH_TRIG_HIGH  = 7'b0000100,
      PH_WAIT_CLEAR = 7'b0001000,
      PH_WAIT_RISE  = 7'b0010000,
      PH_MEASURE    = 7'b0100000,
      PH_GAP        = 7'b1000000
   } phase_type;

   // Item sequencer
   typedef enum logic [5:0] {
      SQ_IDLE     = 6'b000001,
      SQ_SORT_RD  = 6'b000010,
      SQ_SORT_CMP = 6'b000100,
      SQ_FIN      = 6'b001000,
      SQ_MED      = 6'b010000,
      SQ_CONV     = 6'b100000
   } seq_type;

   // Result item, first field in the highest bits
   typedef struct packed {
      logic [10:0] distance_cm;
      logic [15:0] echo_time_us;
      logic        no_echo;
      logic        done_res;
      logic        busy_res;
      logic        trigger_level;
   } result_type;

endpackage

FILE: sv/uerm_ram.sv
module uerm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/uerm_cm_conv.sv
module uerm_cm_conv (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] in_time,
   output logic        out_valid,
   output logic [10:0] out_dist
);

   localparam int N_W    = 17;
   localparam int PROD_W = 28;

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              tz_ff, tz_in;
   logic [10:0]       dist_ff, dist_in;

   logic [10:0]       q0;
   logic [10:0]       q;
   logic [N_W-1:0]    qm;
   logic [N_W-1:0]    rem;

   // Stage one: add rounding, multiply by reciprocal
   assign n_in    = N_W'(in_time) + N_W'(uerm_pkg::CM_ROUND);
   assign prod_in = PROD_W'(n_in) * PROD_W'(uerm_pkg::CM_RECIP);
   assign tz_in   = (in_time == '0);
   assign v1_in   = in_valid;

   // Stage two: quotient is low by at most one, correct on remainder
   assign q0   = prod_ff[26:16];
   assign qm   = N_W'(q0) * N_W'(uerm_pkg::CM_DIV);
   assign rem  = n_ff - qm;
   assign q    = (rem >= N_W'(uerm_pkg::CM_DIV)) ? q0 + 11'd1 : q0;
   assign dist_in = ((q == '0) && !tz_ff) ? 11'd1 : q;
   assign v2_in   = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      prod_ff <= prod_in;
      tz_ff   <= tz_in;
      dist_ff <= dist_in;
   end

   assign out_valid = v2_ff;
   assign out_dist  = dist_ff;

endmodule

FILE: sv/ultrasonic_echo_ranger_median.sv
// An item that ends no ping gives its result in the cycle after it is taken. An item that
// ends a ping with an echo runs an insertion walk over the sample memory, with an
// SQ_SORT_RD and an SQ_SORT_CMP step per entry moved, then, once enough samples are held,
// a median read and a 2-stage conversion to cm. One item at a time, taken only in SQ_IDLE.
// Reset (synchronous, active high) restores register defaults and idles the ranger.
module ultrasonic_echo_ranger_median #(
   parameter int MAX_SAMPLES = 16,
   parameter int TIME_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_level
   input  logic        req_tuser,   // [0] action
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                    // [3] no_echo, [19:4] echo_time_us, [30:20] distance_cm
   // Configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int TGT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

   // Configuration registers
   logic        median_ff, median_in;
   logic [4:0]  sample_ff, sample_in;
   logic [15:0] max_echo_ff, max_echo_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  gap_ms_ff, gap_ms_in;

   // Ranger state
   uerm_pkg::phase_type    phase_ff, phase_in;
   uerm_pkg::seq_type      seq_ff, seq_in;
   logic [TIME_BITS-1:0]   pc_ff, pc_in;
   logic [uerm_pkg::GAP_W-1:0] gap_ff, gap_in;
   logic [TGT_W-1:0]       good_ff, good_in;
   logic [TGT_W-1:0]       target_ff, target_in;
   logic [15:0]            last_ff, last_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [TIME_BITS-1:0]   v_ff, v_in;
   logic [15:0]            rep_ff, rep_in;
   uerm_pkg::result_type   rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Sample memory and converter
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [TIME_BITS-1:0]   ram_wdata;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   logic [TIME_BITS-1:0]   ram_rdata;
   logic                   conv_start;
   logic                   conv_done;
   logic [10:0]            conv_dist;

   logic                   accept;
   logic                   echo;
   logic [TIME_BITS-1:0]   pc_inc;
   logic                   late;
   logic                   echo_full;
   logic [TIME_BITS-1:0]   v_meas;

   uerm_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_SAMPLES)
   ) u_samples (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   uerm_cm_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_start),
      .in_time   (rep_in),
      .out_valid (conv_done),
      .out_dist  (conv_dist)
   );

   // Handshake
   assign req_tready = (seq_ff == uerm_pkg::SQ_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign echo       = req_tdata[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // Counter helpers
   assign pc_inc    = (pc_ff == '1) ? pc_ff : pc_ff + 1'b1;
   assign late      = CMP_W'(pc_ff) >= CMP_W'(timeout_ff);
   assign echo_full = CMP_W'(pc_ff) >= CMP_W'(max_echo_ff);
   assign v_meas    = (pc_ff > TIME_BITS'(uerm_pkg::ECHO_OVERHEAD)) ?
                      pc_ff - TIME_BITS'(uerm_pkg::ECHO_OVERHEAD) : '0;

   // Configuration writes
   always_comb begin
      median_in   = median_ff;
      sample_in   = sample_ff;
      max_echo_in = max_echo_ff;
      timeout_in  = timeout_ff;
      gap_ms_in   = gap_ms_ff;
      if (csr_we) begin
         unique case (csr_addr)
            uerm_pkg::CSR_MEDIAN_MODE:   median_in   = csr_wdata[0];
            uerm_pkg::CSR_SAMPLE_COUNT:  sample_in   = csr_wdata[4:0];
            uerm_pkg::CSR_MAX_ECHO:      max_echo_in = csr_wdata;
            uerm_pkg::CSR_START_TIMEOUT: timeout_in  = csr_wdata;
            uerm_pkg::CSR_PING_GAP:      gap_ms_in   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      logic                 ping_end;
      logic [TIME_BITS-1:0] v;
      int                   n_int;
      logic [7:0]           gap_ms;
      logic [5:0]           back;
      uerm_pkg::result_type res;
      logic                 load;

      ping_end = 1'b0;
      v        = '0;
      n_int    = 1;
      gap_ms   = '0;
      back     = last_ff[15:10];
      res      = '0;
      load     = 1'b0;

      phase_in  = phase_ff;
      seq_in    = seq_ff;
      pc_in     = pc_ff;
      gap_in    = gap_ff;
      good_in   = good_ff;
      target_in = target_ff;
      last_in   = last_ff;
      j_in      = j_ff;
      v_in      = v_ff;
      rep_in    = rep_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      ram_we     = 1'b0;
      ram_waddr  = j_ff;
      ram_wdata  = v_ff;
      ram_re     = 1'b0;
      ram_raddr  = j_ff - 1'b1;
      conv_start = 1'b0;

      unique case (seq_ff)
         uerm_pkg::SQ_IDLE: begin
            if (accept) begin
               if (req_tuser == uerm_pkg::ACT_START) begin
                  // Start a measurement only when idle
                  if (phase_ff == uerm_pkg::PH_IDLE) begin
                     if (sample_ff == '0) begin
                        n_int = 1;
                     end else if (int'(sample_ff) > MAX_SAMPLES) begin
                        n_int = MAX_SAMPLES;
                     end else begin
                        n_int = int'(sample_ff);
                     end
                     target_in = median_ff ? TGT_W'(n_int) : TGT_W'(1);
                     good_in   = '0;
                     pc_in     = '0;
                     gap_in    = '0;
                     phase_in  = uerm_pkg::PH_TRIG_LOW;
                  end
               end else begin
                  // Advance the ping by one microsecond
                  unique case (phase_ff)
                     uerm_pkg::PH_IDLE: phase_in = uerm_pkg::PH_IDLE;
                     uerm_pkg::PH_TRIG_LOW: begin
                        if (pc_inc >= TIME_BITS'(uerm_pkg::TRIG_LOW_TICKS)) begin
                           phase_in = uerm_pkg::PH_TRIG_HIGH;
                           pc_in    = '0;
                        end else begin
                           pc_in = pc_inc;
                        end
                     end
                     uerm_pkg::PH_TRIG_HIGH: begin
                        if (pc_inc >= TIME_BITS'(uerm_pkg::TRIG_HIGH_TICKS)) begin
                           phase_in = uerm_pkg::PH_WAIT_CLEAR;
                           pc_in    = '0;
                        end else begin
                           pc_in = pc_inc;
                        end
                     end
                     uerm_pkg::PH_WAIT_CLEAR, uerm_pkg::PH_WAIT_RISE: begin
                        pc_in = pc_inc;
                        if (echo) begin
                           if (phase_ff == uerm_pkg::PH_WAIT_RISE || late) begin
                              phase_in = uerm_pkg::PH_MEASURE;
                              pc_in    = TIME_BITS'(1);
                           end
                        end else if (late) begin
                           ping_end = 1'b1;
                        end else begin
                           phase_in = uerm_pkg::PH_WAIT_RISE;
                        end
                     end
                     uerm_pkg::PH_MEASURE: begin
                        if (echo) begin
                           if (echo_full) begin
                              ping_end = 1'b1;
                           end else begin
                              pc_in = pc_inc;
                           end
                        end else begin
                           ping_end = 1'b1;
                           v        = v_meas;
                        end
                     end
                     uerm_pkg::PH_GAP: begin
                        if (gap_ff <= uerm_pkg::GAP_W'(1)) begin
                           gap_in   = '0;
                           phase_in = uerm_pkg::PH_TRIG_LOW;
                           pc_in    = '0;
                        end else begin
                           gap_in = gap_ff - 1'b1;
                        end
                     end
                     default: phase_in = uerm_pkg::PH_IDLE;
                  endcase
               end

               if (ping_end) begin
                  if (v == '0) begin
                     // Failed ping: lower the target
                     if (target_ff != '0) begin
                        target_in = target_ff - 1'b1;
                     end
                     last_in = max_echo_ff;
                     seq_in  = uerm_pkg::SQ_FIN;
                  end else begin
                     // Good ping: start the insertion walk at the fill point
                     j_in = (int'(good_ff) >= MAX_SAMPLES - 1) ?
                            IDX_W'(MAX_SAMPLES - 1) : IDX_W'(good_ff);
                     if (int'(good_ff) < MAX_SAMPLES) begin
                        good_in = good_ff + 1'b1;
                     end
                     last_in = 16'(v);
                     v_in    = v;
                     seq_in  = uerm_pkg::SQ_SORT_RD;
                  end
               end else begin
                  res.trigger_level = (phase_in == uerm_pkg::PH_TRIG_HIGH);
                  res.busy_res      = (phase_in != uerm_pkg::PH_IDLE);
                  load = 1'b1;
               end
            end
         end

         uerm_pkg::SQ_SORT_RD: begin
            if (j_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = v_ff;
               seq_in    = uerm_pkg::SQ_FIN;
            end else begin
               ram_re = 1'b1;
               seq_in = uerm_pkg::SQ_SORT_CMP;
            end
         end

         uerm_pkg::SQ_SORT_CMP: begin
            ram_we = 1'b1;
            if (ram_rdata < v_ff) begin
               // Shift the smaller entry down one place
               ram_wdata = ram_rdata;
               j_in      = j_ff - 1'b1;
               seq_in    = uerm_pkg::SQ_SORT_RD;
            end else begin
               ram_wdata = v_ff;
               seq_in    = uerm_pkg::SQ_FIN;
            end
         end

         uerm_pkg::SQ_FIN: begin
            if (good_ff >= target_ff) begin
               if (good_ff != '0) begin
                  // Fetch the middle entry
                  ram_re    = 1'b1;
                  ram_raddr = IDX_W'(target_ff >> 1);
                  seq_in    = uerm_pkg::SQ_MED;
               end else begin
                  res.done_res = 1'b1;
                  res.no_echo  = 1'b1;
                  phase_in = uerm_pkg::PH_IDLE;
                  pc_in    = '0;
                  gap_in   = '0;
                  load     = 1'b1;
                  seq_in   = uerm_pkg::SQ_IDLE;
               end
            end else begin
               // Schedule the next ping after the pause
               gap_ms = (gap_ms_ff > 8'(back)) ? gap_ms_ff - 8'(back) : '0;
               pc_in  = '0;
               if (gap_ms == '0) begin
                  phase_in = uerm_pkg::PH_TRIG_LOW;
               end else begin
                  gap_in   = uerm_pkg::GAP_W'(gap_ms) *
                             uerm_pkg::GAP_W'(uerm_pkg::GAP_US_PER_MS);
                  phase_in = uerm_pkg::PH_GAP;
               end
               res.busy_res = 1'b1;
               load   = 1'b1;
               seq_in = uerm_pkg::SQ_IDLE;
            end
         end

         uerm_pkg::SQ_MED: begin
            rep_in     = 16'(ram_rdata);
            conv_start = 1'b1;
            seq_in     = uerm_pkg::SQ_CONV;
         end

         uerm_pkg::SQ_CONV: begin
            if (conv_done) begin
               res.done_res     = 1'b1;
               res.no_echo      = (rep_ff == '0);
               res.echo_time_us = rep_ff;
               res.distance_cm  = (rep_ff == '0) ? '0 : conv_dist;
               phase_in = uerm_pkg::PH_IDLE;
               pc_in    = '0;
               gap_in   = '0;
               load     = 1'b1;
               seq_in   = uerm_pkg::SQ_IDLE;
            end
         end

         default: seq_in = uerm_pkg::SQ_IDLE;
      endcase

      // Load the output register
      if (load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         median_ff    <= uerm_pkg::RST_MEDIAN_MODE;
         sample_ff    <= uerm_pkg::RST_SAMPLE_COUNT;
         max_echo_ff  <= uerm_pkg::RST_MAX_ECHO;
         timeout_ff   <= uerm_pkg::RST_START_TIMEOUT;
         gap_ms_ff    <= uerm_pkg::RST_PING_GAP;
         phase_ff     <= uerm_pkg::PH_IDLE;
         seq_ff       <= uerm_pkg::SQ_IDLE;
         pc_ff        <= '0;
         gap_ff       <= '0;
         good_ff      <= '0;
         target_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         median_ff    <= median_in;
         sample_ff    <= sample_in;
         max_echo_ff  <= max_echo_in;
         timeout_ff   <= timeout_in;
         gap_ms_ff    <= gap_ms_in;
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         pc_ff        <= pc_in;
         gap_ff       <= gap_in;
         good_ff      <= good_in;
         target_ff    <= target_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      v_ff   <= v_in;
      rep_ff <= rep_in;
      rsp_ff <= rsp_in;
   end

endmodule
